>>> design/cfss_pkg.sv
`default_nettype none

package cfss_pkg;

  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned HALF_W      = 7;
  localparam int unsigned FACTOR_W    = 16;
  localparam int unsigned ROUND_SHIFT = 15;
  localparam int unsigned ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_HALF_ROWS    = 4'd0;
  localparam cfg_idx_t REG_HALF_COLS    = 4'd1;
  localparam cfg_idx_t REG_SCALE_ENABLE = 4'd2;
  localparam cfg_idx_t REG_SCALE_FACTOR = 4'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [HALF_W-1:0]   HALF_RESET   = 7'd64;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd32768;

  typedef struct packed {
    logic [HALF_W-1:0] half_rows;
    logic [HALF_W-1:0] half_cols;
  } size_cfg_t;

  typedef struct packed {
    logic                enable;
    logic [FACTOR_W-1:0] factor;
  } scale_cfg_t;

endpackage

`default_nettype wire

>>> design/cfss_if.sv
`default_nettype none

interface cfss_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [SAMPLE_BITS-1:0] in_real;
  logic signed [SAMPLE_BITS-1:0] in_imag;

  modport source (output valid, cmd, in_real, in_imag, input ready);
  modport sink   (input valid, cmd, in_real, in_imag, output ready);
endinterface

interface cfss_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_real;
  logic signed [SAMPLE_BITS-1:0] out_imag;
  logic                          last_of_frame;

  modport source (output valid, out_real, out_imag, last_of_frame, input ready);
  modport sink   (input valid, out_real, out_imag, last_of_frame, output ready);
endinterface

interface cfss_cfg_if import cfss_pkg::*;;
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

>>> design/cfss_addr_gen.sv
`default_nettype none

module cfss_addr_gen import cfss_pkg::*; #(
  parameter int unsigned MAX_DIM = 128
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire size_cfg_t                            size_i,
  input  wire logic                                 wr_en_i,
  input  wire logic                                 rd_en_i,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        wr_addr_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        rd_addr_o,
  output logic                                      rd_last_o
);

  localparam int unsigned CW       = $clog2(MAX_DIM + 1);
  localparam int unsigned DEPTH    = MAX_DIM * MAX_DIM;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned TW       = $clog2(DEPTH + 1);
  localparam int unsigned MAX_HALF = MAX_DIM / 2;

  function automatic logic [CW-1:0] clamp_half(logic [HALF_W-1:0] h);
    logic [CW-1:0] r;
    if (h == '0) begin
      r = CW'(1);
    end else if (32'(h) > 32'(MAX_HALF)) begin
      r = CW'(MAX_HALF);
    end else begin
      r = CW'(h);
    end
    return r;
  endfunction

  logic [CW-1:0] hr, hc, rows, cols;
  logic [TW-1:0] total;
  logic [AW-1:0] wpos_q, wpos_d, wr_pos;
  logic [TW-1:0] wr_next;
  logic [CW-1:0] rr_q, rr_d, rc_q, rc_d, rr_cur, rc_cur, sr, sc;
  logic [CW:0]   sr_sum, sc_sum, sr_wrap, sc_wrap, rr_inc, rc_inc;
  logic [TW-1:0] rd_lin;
  logic          restart;

  assign hr    = clamp_half(size_i.half_rows);
  assign hc    = clamp_half(size_i.half_cols);
  assign rows  = {hr[CW-2:0], 1'b0};
  assign cols  = {hc[CW-2:0], 1'b0};
  assign total = TW'(rows) * TW'(cols);

  assign wr_pos    = (TW'(wpos_q) >= total) ? '0 : wpos_q;
  assign wr_next   = TW'(wr_pos) + TW'(1);
  assign wpos_d    = (wr_next >= total) ? '0 : wr_next[AW-1:0];
  assign wr_addr_o = wr_pos;

  assign restart = (rr_q >= rows) || (rc_q >= cols);
  assign rr_cur  = restart ? '0 : rr_q;
  assign rc_cur  = restart ? '0 : rc_q;

  assign sr_sum  = {1'b0, rr_cur} + {1'b0, hr};
  assign sc_sum  = {1'b0, rc_cur} + {1'b0, hc};
  assign sr_wrap = (sr_sum >= {1'b0, rows}) ? (sr_sum - {1'b0, rows}) : sr_sum;
  assign sc_wrap = (sc_sum >= {1'b0, cols}) ? (sc_sum - {1'b0, cols}) : sc_sum;
  assign sr      = sr_wrap[CW-1:0];
  assign sc      = sc_wrap[CW-1:0];

  assign rd_lin    = TW'(sr) * TW'(cols) + TW'(sc);
  assign rd_addr_o = rd_lin[AW-1:0];
  assign rd_last_o = (rr_cur == rows - CW'(1)) && (rc_cur == cols - CW'(1));

  assign rc_inc = {1'b0, rc_cur} + (CW+1)'(1);
  assign rr_inc = {1'b0, rr_cur} + (CW+1)'(1);

  always_comb begin
    rr_d = rr_cur;
    rc_d = rc_inc[CW-1:0];
    if (rc_inc >= {1'b0, cols}) begin
      rc_d = '0;
      rr_d = (rr_inc >= {1'b0, rows}) ? '0 : rr_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
      rr_q   <= '0;
      rc_q   <= '0;
    end else begin
      if (wr_en_i) begin
        wpos_q <= wpos_d;
      end
      if (rd_en_i) begin
        rr_q <= rr_d;
        rc_q <= rc_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/cfss_frame_mem.sv
`default_nettype none

module cfss_frame_mem #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]              rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> design/cfss_scale.sv
`default_nettype none

module cfss_scale import cfss_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire scale_cfg_t                    scale_i,
  input  wire logic                          valid_i,
  input  wire logic                          last_i,
  input  wire logic signed [SAMPLE_BITS-1:0] real_i,
  input  wire logic signed [SAMPLE_BITS-1:0] imag_i,
  output logic                               ready_o,
  cfss_out_if.source                         out_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned PW = SB + FACTOR_W + 1;
  localparam int unsigned QW = PW + 1;
  localparam int unsigned RW = QW - ROUND_SHIFT;

  function automatic logic [SB-1:0] round_sat(logic signed [PW-1:0] p);
    logic signed [QW-1:0] q;
    logic [RW-1:0]        r;
    logic [SB-1:0]        res;
    q = QW'(p) + QW'(ROUND_BIAS);
    r = q[QW-1:ROUND_SHIFT];
    if ((r[RW-1:SB-1] == '0) || (r[RW-1:SB-1] == '1)) begin
      res = r[SB-1:0];
    end else if (r[RW-1]) begin
      res = {1'b1, {(SB-1){1'b0}}};
    end else begin
      res = {1'b0, {(SB-1){1'b1}}};
    end
    return res;
  endfunction

  logic signed [FACTOR_W:0] factor_s;
  logic signed [PW-1:0]     prod_re, prod_im;
  logic signed [PW-1:0]     prod_re_q, prod_im_q;
  logic signed [SB-1:0]     raw_re_q, raw_im_q;
  logic                     v2_q, last2_q, en2, en_out;
  logic                     ov_q, olast_q;
  logic [SB-1:0]            ore_q, oim_q, ore_d, oim_d;

  assign factor_s = $signed({1'b0, scale_i.factor});
  assign prod_re  = real_i * factor_s;
  assign prod_im  = imag_i * factor_s;

  assign en_out  = !ov_q || out_o.ready;
  assign en2     = !v2_q || en_out;
  assign ready_o = en2;

  assign ore_d = scale_i.enable ? round_sat(prod_re_q) : raw_re_q;
  assign oim_d = scale_i.enable ? round_sat(prod_im_q) : raw_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en2) begin
        v2_q <= valid_i;
      end
      if (en_out) begin
        ov_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      prod_re_q <= prod_re;
      prod_im_q <= prod_im;
      raw_re_q  <= real_i;
      raw_im_q  <= imag_i;
      last2_q   <= last_i;
    end
    if (en_out) begin
      ore_q   <= ore_d;
      oim_q   <= oim_d;
      olast_q <= last2_q;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.out_real      = ore_q;
  assign out_o.out_imag      = oim_q;
  assign out_o.last_of_frame = olast_q;

endmodule

`default_nettype wire

>>> design/complex_fftshift_scale.sv
// Complex frame store with a 2D quadrant swap (fftshift) and optional unsigned Q1.15
// scaling. A write transaction (cmd 0) stores one sample at the next row-major
// position; a read transaction (cmd 1) returns the next element of the shifted frame,
// with last_of_frame set on its final element. One transaction is taken per clock
// cycle unless the output stalls; a read result passes through the synchronous frame
// memory read, the product register and the round/saturate output register. The frame
// memory has one write port and one read port, holds MAX_DIM*MAX_DIM samples and
// needs no clearing after reset. Write a frame completely before reading it. The
// user must change sizes and scaling only while idle; the block does not enforce it.
`default_nettype none

module complex_fftshift_scale import cfss_pkg::*; #(
  parameter int unsigned MAX_DIM     = 128,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cfss_cfg_if.sink   cfg_i,
  cfss_in_if.sink    in_i,
  cfss_out_if.source out_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SB    = SAMPLE_BITS;

  size_cfg_t  size_q;
  scale_cfg_t scale_q;

  logic          en1, s1_ready, in_acc, wr_en, rd_en, rd_last;
  logic          v1_q, last1_q;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [2*SB-1:0] rd_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q.half_rows <= HALF_RESET;
      size_q.half_cols <= HALF_RESET;
      scale_q.enable   <= 1'b0;
      scale_q.factor   <= FACTOR_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_HALF_ROWS:    size_q.half_rows <= cfg_i.wdata[HALF_W-1:0];
        REG_HALF_COLS:    size_q.half_cols <= cfg_i.wdata[HALF_W-1:0];
        REG_SCALE_ENABLE: scale_q.enable   <= cfg_i.wdata[0];
        REG_SCALE_FACTOR: scale_q.factor   <= cfg_i.wdata[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign en1        = !v1_q || s1_ready;
  assign in_i.ready = en1;
  assign in_acc     = in_i.valid && en1;
  assign wr_en      = in_acc && (in_i.cmd == CMD_WRITE);
  assign rd_en      = in_acc && (in_i.cmd == CMD_READ);

  cfss_addr_gen #(
    .MAX_DIM (MAX_DIM)
  ) u_addr_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .size_i    (size_q),
    .wr_en_i   (wr_en),
    .rd_en_i   (rd_en),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr),
    .rd_last_o (rd_last)
  );

  cfss_frame_mem #(
    .DEPTH (DEPTH),
    .WIDTH (2 * SB)
  ) u_frame_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i ({in_i.in_real, in_i.in_imag}),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      last1_q <= rd_last;
    end
  end

  cfss_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scale_i (scale_q),
    .valid_i (v1_q),
    .last_i  (last1_q),
    .real_i  ($signed(rd_data[2*SB-1:SB])),
    .imag_i  ($signed(rd_data[SB-1:0])),
    .ready_o (s1_ready),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  a_read_fills_stage1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> v1_q)
    else $error("Accepted read did not reach the memory output stage.");

  a_write_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> !v1_q)
    else $error("Accepted write produced a pending result.");

  a_stall_holds_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !s1_ready) |=> (v1_q && $stable(rd_data) && $stable(last1_q)))
    else $error("Memory read data changed while the next stage was stalled.");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb import cfss_pkg::*;;

  localparam int unsigned MAX_DIM       = 128;
  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned STORE_DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned ITEM_TARGET   = 1650;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PAD_W         = CFG_DATA_W - HALF_W;
  localparam cfg_idx_t    REG_INDEX_LAST = '1;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam longint LIM_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint LIM_MIN = -(longint'(1) <<< (SAMPLE_BITS - 1));

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic                          last;
  } sample_t;

  typedef enum logic {ROW_CONFIG, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    cfg_idx_t                      index;
    logic [CFG_DATA_W-1:0]         wdata;
    logic                          cmd;
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
    logic                          typed;
    sample_t                       want;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;

  cfss_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  cfss_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_if ();
  cfss_cfg_if                              cfg_if ();

  complex_fftshift_scale #(
    .MAX_DIM    (MAX_DIM),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic [SAMPLE_BITS-1:0] frame_re [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] frame_im [STORE_DEPTH];
  bit                     written  [STORE_DEPTH];
  int unsigned            write_pos;
  int unsigned            out_row;
  int unsigned            out_col;

  logic [HALF_W-1:0]   half_rows_reg;
  logic [HALF_W-1:0]   half_cols_reg;
  logic                scale_on;
  logic [FACTOR_W-1:0] scale_factor_reg;

  sample_t       shifted_q [$];
  directed_row_t directed_rows [$];
  int unsigned   error_count;
  int unsigned   items_sent;
  bit            steady;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int unsigned eff_half(input logic [HALF_W-1:0] h);
    if (h < 1) return 1;
    if (h > MAX_DIM / 2) return MAX_DIM / 2;
    return 32'(h);
  endfunction

  function automatic void apply_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_HALF_ROWS: begin
        half_rows_reg = v[HALF_W-1:0];
      end
      REG_HALF_COLS: begin
        half_cols_reg = v[HALF_W-1:0];
      end
      REG_SCALE_ENABLE: begin
        scale_on = v[0];
      end
      REG_SCALE_FACTOR: begin
        scale_factor_reg = v[FACTOR_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] scale_part(
    input logic signed [SAMPLE_BITS-1:0] x
  );
    longint prod;
    if (!scale_on) return x;
    prod = (longint'(x) * longint'(scale_factor_reg) + longint'(ROUND_BIAS)) >>> ROUND_SHIFT;
    if (prod > LIM_MAX) prod = LIM_MAX;
    if (prod < LIM_MIN) prod = LIM_MIN;
    return prod[SAMPLE_BITS-1:0];
  endfunction

  function automatic void store_sample(input logic [SAMPLE_BITS-1:0] re,
                                       input logic [SAMPLE_BITS-1:0] im);
    int unsigned total;
    int unsigned pos;
    total = 4 * eff_half(half_rows_reg) * eff_half(half_cols_reg);
    pos = write_pos;
    if (pos >= total) pos = 0;
    frame_re[pos] = re;
    frame_im[pos] = im;
    written[pos] = 1'b1;
    pos++;
    write_pos = (pos >= total) ? 0 : pos;
  endfunction

  function automatic void locate_read(output int unsigned addr, output logic last,
                                      output int unsigned row, output int unsigned col);
    int unsigned hr;
    int unsigned hc;
    int unsigned sr;
    int unsigned sc;
    hr = eff_half(half_rows_reg);
    hc = eff_half(half_cols_reg);
    row = out_row;
    col = out_col;
    if (row >= 2 * hr || col >= 2 * hc) begin
      row = 0;
      col = 0;
    end
    sr = row + hr;
    sc = col + hc;
    if (sr >= 2 * hr) sr -= 2 * hr;
    if (sc >= 2 * hc) sc -= 2 * hc;
    addr = sr * 2 * hc + sc;
    last = (row == 2 * hr - 1) && (col == 2 * hc - 1);
  endfunction

  function automatic sample_t fftshift_predict();
    sample_t     res;
    int unsigned addr;
    int unsigned row;
    int unsigned col;
    logic        last;
    locate_read(addr, last, row, col);
    res.re = scale_part(frame_re[addr]);
    res.im = scale_part(frame_im[addr]);
    res.last = last;
    col++;
    if (col >= 2 * eff_half(half_cols_reg)) begin
      col = 0;
      row++;
      if (row >= 2 * eff_half(half_rows_reg)) row = 0;
    end
    out_row = row;
    out_col = col;
    return res;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_part();
    case ($urandom_range(0, 11))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic directed_row_t row_config(input cfg_idx_t idx,
                                               input logic [CFG_DATA_W-1:0] v);
    directed_row_t r;
    r = '0;
    r.kind = ROW_CONFIG;
    r.index = idx;
    r.wdata = v;
    return r;
  endfunction

  function automatic directed_row_t row_write(input logic signed [SAMPLE_BITS-1:0] re,
                                              input logic signed [SAMPLE_BITS-1:0] im);
    directed_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.cmd = CMD_WRITE;
    r.re = re;
    r.im = im;
    return r;
  endfunction

  function automatic directed_row_t row_read();
    directed_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.cmd = CMD_READ;
    return r;
  endfunction

  function automatic directed_row_t row_checked(input logic signed [SAMPLE_BITS-1:0] re,
                                                input logic signed [SAMPLE_BITS-1:0] im,
                                                input logic last);
    directed_row_t r;
    r = row_read();
    r.typed = 1'b1;
    r.want.re = re;
    r.want.im = im;
    r.want.last = last;
    return r;
  endfunction

  task automatic send_sample(input logic cmd, input logic signed [SAMPLE_BITS-1:0] re,
                             input logic signed [SAMPLE_BITS-1:0] im, input logic typed,
                             input sample_t typed_result);
    int unsigned gap;
    sample_t     res;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.cmd     <= cmd;
    in_if.in_real <= re;
    in_if.in_imag <= im;
    do @(posedge clk_i); while (!in_if.ready);
    if (cmd == CMD_READ) begin
      res = fftshift_predict();
      shifted_q.push_back(typed ? typed_result : res);
    end else begin
      store_sample(re, im);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_register(idx, v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (shifted_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned phase_no);
    logic [HALF_W-1:0]   hr;
    logic [HALF_W-1:0]   hc;
    logic [FACTOR_W-1:0] factor;
    int unsigned         total;
    int unsigned         count;
    int unsigned         addr;
    int unsigned         row;
    int unsigned         col;
    logic                last;
    logic                cmd;
    sample_t             none;
    none = '0;
    if (phase_no == 0) begin
      hr = HALF_W'(MAX_DIM / 2);
      hc = HALF_W'(1);
    end else if (phase_no == 1) begin
      hr = '0;
      hc = '1;
    end else if ($urandom_range(0, 9) == 0) begin
      hr = HALF_W'($urandom_range(MAX_DIM / 2 + 1, 2 ** HALF_W - 1));
      hc = HALF_W'($urandom_range(0, 1));
      if ($urandom_range(0, 1) == 1) begin
        {hr, hc} = {hc, hr};
      end
    end else begin
      hr = HALF_W'($urandom_range(0, 4));
      hc = HALF_W'($urandom_range(0, 4));
    end
    case ($urandom_range(0, 4))
      0: factor = FACTOR_RESET;
      1: factor = '0;
      2: factor = '1;
      default: factor = FACTOR_W'($urandom);
    endcase
    wait_idle();
    steady = ($urandom_range(0, 3) == 0);
    write_register(REG_HALF_ROWS, {PAD_W'($urandom), hr});
    write_register(REG_HALF_COLS, {PAD_W'($urandom), hc});
    write_register(REG_SCALE_ENABLE, CFG_DATA_W'($urandom));
    write_register(REG_SCALE_FACTOR, factor);
    if ($urandom_range(0, 3) == 0) begin
      write_register(cfg_idx_t'($urandom_range(REG_SCALE_FACTOR + 1, REG_INDEX_LAST)),
                     CFG_DATA_W'($urandom));
    end
    total = 4 * eff_half(half_rows_reg) * eff_half(half_cols_reg);
    if ($urandom_range(0, 3) != 0) begin
      repeat (total) send_sample(CMD_WRITE, random_part(), random_part(), 1'b0, none);
      repeat (total) send_sample(CMD_READ, random_part(), random_part(), 1'b0, none);
    end else begin
      count = $urandom_range(1, 40);
      for (int unsigned k = 0; k < count; k++) begin
        if (k == count / 2 && $urandom_range(0, 1) == 1) begin
          wait_idle();
        end
        cmd = ($urandom_range(0, 1) == 1) ? CMD_READ : CMD_WRITE;
        if (cmd == CMD_READ) begin
          locate_read(addr, last, row, col);
          if (!written[addr]) cmd = CMD_WRITE;
        end
        send_sample(cmd, random_part(), random_part(), 1'b0, none);
      end
    end
  endtask

  always @(posedge clk_i) begin
    sample_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (shifted_q.size() == 0) begin
        report_mismatch($sformatf("result with no expectation: re %0d im %0d last %0b",
                                  out_if.out_real, out_if.out_imag, out_if.last_of_frame));
      end else begin
        want = shifted_q.pop_front();
        if (out_if.out_real !== want.re) begin
          report_mismatch($sformatf("out_real got %0d expected %0d", out_if.out_real, want.re));
        end
        if (out_if.out_imag !== want.im) begin
          report_mismatch($sformatf("out_imag got %0d expected %0d", out_if.out_imag, want.im));
        end
        if (out_if.last_of_frame !== want.last) begin
          report_mismatch($sformatf("last_of_frame got %0b expected %0b",
                                    out_if.last_of_frame, want.last));
        end
      end
    end
  end

  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = steady ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  initial begin
    int unsigned phase_no;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_WRITE;
    in_if.in_real    = '0;
    in_if.in_imag    = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_HALF_ROWS;
    cfg_if.wdata     = '0;
    half_rows_reg    = HALF_RESET;
    half_cols_reg    = HALF_RESET;
    scale_on         = 1'b0;
    scale_factor_reg = FACTOR_RESET;
    write_pos        = 0;
    out_row          = 0;
    out_col          = 0;
    error_count      = 0;
    items_sent       = 0;
    steady           = 1'b0;
    phase_no         = 0;

    // The 2x2 frame makes the swapped order easy to see: the last written sample comes out first.
    directed_rows = '{
      row_config(REG_HALF_ROWS, 16'd1),
      row_config(REG_HALF_COLS, 16'd1),
      row_write(S_MAX, S_MIN),
      row_write(S_MIN, S_MAX),
      row_write(-16'sd1, 16'sd0),
      row_write(16'sd1, -16'sd1),
      row_checked(16'sd1, -16'sd1, 1'b0),
      row_checked(-16'sd1, 16'sd0, 1'b0),
      row_checked(S_MIN, S_MAX, 1'b0),
      row_checked(S_MAX, S_MIN, 1'b1),
      row_config(REG_SCALE_ENABLE, 16'd1),
      row_config(REG_SCALE_FACTOR, 16'hFFFF),
      row_read(),
      row_read(),
      row_read(),
      row_read(),
      row_config(REG_SCALE_FACTOR, 16'd16384),
      row_write(16'sd1, -16'sd1),
      row_write(16'sd3, -16'sd3),
      row_write(S_MIN, S_MAX),
      row_write(S_MAX, -16'sd2),
      row_read(),
      row_read(),
      row_read(),
      row_read(),
      row_config(REG_SCALE_FACTOR, 16'd0),
      row_checked(16'sd0, 16'sd0, 1'b0),
      row_checked(16'sd0, 16'sd0, 1'b0),
      row_checked(16'sd0, 16'sd0, 1'b0),
      row_checked(16'sd0, 16'sd0, 1'b1)
    };

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        wait_idle();
        write_register(directed_rows[i].index, directed_rows[i].wdata);
      end else begin
        send_sample(directed_rows[i].cmd, directed_rows[i].re, directed_rows[i].im,
                    directed_rows[i].typed, directed_rows[i].want);
      end
    end

    while (items_sent < ITEM_TARGET) begin
      run_random_phase(phase_no);
      phase_no++;
    end

    wait_idle();
    if (error_count == 0 && shifted_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> complex_fftshift_scale.f
design/cfss_pkg.sv
design/cfss_if.sv
design/cfss_addr_gen.sv
design/cfss_frame_mem.sv
design/cfss_scale.sv
design/complex_fftshift_scale.sv
tb/sv/tb.sv
